// ===== rtl/bncl_pkg.sv =====
// Shared types for the bounded nearest-candidate list.
// Holds the list entry layout and the controller state encoding; no dependencies.
package bncl_pkg;

  typedef struct packed {
    logic [31:0] vertex_key;
    logic [31:0] distance;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } bncl_state_t;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

endpackage

// ===== rtl/bncl_mem.sv =====
// Entry store of the candidate list: one write port, one read port, registered read data.
// Depends on bncl_pkg for the entry layout.
module bncl_mem
  import bncl_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_q[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bncl_ctrl.sv =====
// Scan and shift sequencer of the candidate list, including the held entry count.
// Depends on bncl_pkg; drives the ports of bncl_mem.
module bncl_ctrl
  import bncl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [4:0]    cfg_capacity,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   in_vertex_key,
  input  logic [31:0]   in_distance,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output entry_t        mem_wr_data,
  output logic [AW-1:0] mem_rd_addr,
  input  entry_t        mem_rd_data,
  output logic          res_valid,
  input  logic          res_ready,
  output logic          res_accepted,
  output logic [CW-1:0] res_count
);

  localparam logic [CW-1:0] MAX_C   = CW'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_IX = AW'(MAX_ENTRIES - 1);

  bncl_state_t   state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          acc_r, acc_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   dist_r, dist_nxt;
  entry_t        carry_r, carry_nxt;
  logic [31:0]   cap_wide;
  logic [CW-1:0] cap_eff;
  logic [AW-1:0] idx_inc;

  always_comb begin
    cap_wide = {27'd0, cfg_capacity};
    if (cap_wide == 32'd0) begin
      cap_eff = CW'(1);
    end else if (cap_wide > 32'(MAX_ENTRIES)) begin
      cap_eff = MAX_C;
    end else begin
      cap_eff = CW'(cap_wide);
    end
  end

  assign idx_inc = idx_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    n_r     <= n_nxt;
    cap_r   <= cap_nxt;
    key_r   <= key_nxt;
    dist_r  <= dist_nxt;
    carry_r <= carry_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    n_nxt       = n_r;
    cap_nxt     = cap_r;
    held_nxt    = held_r;
    acc_nxt     = acc_r;
    key_nxt     = key_r;
    dist_nxt    = dist_r;
    carry_nxt   = carry_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = '{vertex_key: key_r, distance: dist_r};
    mem_rd_addr = idx_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt     = in_vertex_key;
          dist_nxt    = in_distance;
          cap_nxt     = cap_eff;
          n_nxt       = held_r;
          idx_nxt     = '0;
          mem_rd_addr = '0;
          if (held_r < MAX_C) begin
            last_nxt = AW'(held_r);
          end else begin
            last_nxt = LAST_IX;
          end
          if (held_r == '0) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = '{vertex_key: in_vertex_key, distance: in_distance};
            held_nxt    = CW'(1);
            acc_nxt     = 1'b1;
            state_nxt   = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (mem_rd_data.vertex_key == key_r) begin
          acc_nxt   = 1'b0;
          state_nxt = ST_RESP;
        end else if (dist_r < mem_rd_data.distance) begin
          mem_wr_en = 1'b1;
          carry_nxt = mem_rd_data;
          acc_nxt   = 1'b1;
          if (n_r < cap_r) begin
            held_nxt = n_r + CW'(1);
          end else begin
            held_nxt = n_r;
          end
          if (idx_r == last_r) begin
            state_nxt = ST_RESP;
          end else begin
            mem_rd_addr = idx_inc;
            idx_nxt     = idx_inc;
            state_nxt   = ST_SHIFT;
          end
        end else if (CW'(idx_r) + CW'(1) == n_r) begin
          if (n_r < cap_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(n_r);
            held_nxt    = n_r + CW'(1);
            acc_nxt     = 1'b1;
          end else begin
            acc_nxt = 1'b0;
          end
          state_nxt = ST_RESP;
        end else begin
          mem_rd_addr = idx_inc;
          idx_nxt     = idx_inc;
        end
      end

      ST_SHIFT: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = carry_r;
        carry_nxt   = mem_rd_data;
        if (idx_r == last_r) begin
          state_nxt = ST_RESP;
        end else begin
          mem_rd_addr = idx_inc;
          idx_nxt     = idx_inc;
        end
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_accepted = acc_r;
  assign res_count    = held_r;

endmodule

// ===== rtl/bounded_nearest_candidate_list.sv =====
// Bounded nearest-candidate list: up to capacity (key, distance) entries kept in
// ascending distance order. An offer beat on the in_ channel carries a vertex key and
// an unsigned Q16.16 distance. The list is scanned from the nearest entry; an equal key
// met before the insertion point rejects the offer, otherwise it is inserted in front of
// the first strictly larger distance (ties go behind), dropping the farthest entry when
// the list is full, or appended when there is room.
// Each offer yields one result beat on the out_ channel with the accepted flag and the
// entry count after the offer.
// Entries live in a single-port-write, single-port-read memory with registered read
// data. An offer reads the entries one by one while scanning, and when it inserts,
// moves each entry behind it up one place before the result is offered. One offer
// is in work at a time; the next is taken in the cycle after its result moves to the
// output register. A result waiting on out_ready sits in that register while the next
// offer is scanned; a finished result waits in the sequencer until the register frees.
// Reset empties the list and sets capacity to 16; no clearing pass is needed.
// cfg_wr_en writes the capacity register; it must be written only while idle.
module bounded_nearest_candidate_list
  import bncl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_vertex_key,
  input  logic [31:0] in_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [4:0]  out_entry_count
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [4:0]    capacity_r;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;
  logic          res_valid;
  logic          res_ready;
  logic          res_accepted;
  logic [CW-1:0] res_count;
  logic [31:0]   res_count_wide;
  logic          out_valid_r;
  logic          out_accepted_r;
  logic [4:0]    out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  bncl_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bncl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_capacity  (capacity_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vertex_key (in_vertex_key),
    .in_distance   (in_distance),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_accepted  (res_accepted),
    .res_count     (res_count)
  );

  assign res_ready      = !out_valid_r || out_ready;
  assign res_count_wide = 32'(res_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_accepted_r <= res_accepted;
      out_count_r    <= res_count_wide[4:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_entry_count = out_count_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("offer accepted while the previous one was still in work");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |-> !out_valid_r || out_ready)
    else $error("result loaded over an untaken output beat");

  a_result_before_next: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> !in_ready)
    else $error("new offer taken while a result is still pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> 32'(res_count) <= 32'(MAX_ENTRIES))
    else $error("held count exceeds the list depth");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for bounded_nearest_candidate_list, driven through valid/ready.
// Runs a directed table, then random offers under several capacity settings; typed
// rows check against the table, others against a predictor. Depends on bncl_pkg, RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bncl_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int SETTLE_CYCLES = MAX_ENTRIES + 4;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES = 12;
  localparam logic [4:0] CAP_PLAN [NUM_PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd17, 5'd12, 5'd3, 5'd16, 5'd8, 5'd30
  };

  typedef struct packed {
    logic       accepted;
    logic [4:0] entry_count;
  } verdict_t;

  typedef enum logic {ROW_OFFER, ROW_SET_CAP} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] key;
    logic [31:0] dist_val;
    logic [4:0]  cap;
    bit          typed;
    logic        want_acc;
    logic [4:0]  want_cnt;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = CAPACITY_RESET;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_vertex_key = '0;
  logic [31:0] in_distance = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [4:0]  out_entry_count;

  entry_t      cand_list [MAX_ENTRIES];
  int unsigned cand_count = 0;
  logic [4:0]  cap_setting = CAPACITY_RESET;
  verdict_t    pending_verdicts [$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;
  script_row_t script [21];

  bounded_nearest_candidate_list #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_vertex_key(in_vertex_key),
    .in_distance(in_distance),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_accepted(out_accepted),
    .out_entry_count(out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic verdict_t rank_offer(input logic [31:0] key,
                                          input logic [31:0] off_dist);
    int unsigned cap_eff;
    int unsigned n;
    int          top;
    int          slot;
    bit          hit;
    verdict_t    v;
    cap_eff = (cap_setting == 5'd0) ? 1 : cap_setting;
    if (cap_eff > MAX_ENTRIES) cap_eff = MAX_ENTRIES;
    n = cand_count;
    slot = -1;
    hit = 1'b0;
    v.accepted = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!hit && slot < 0) begin
        if (cand_list[i].vertex_key == key) hit = 1'b1;
        else if (off_dist < cand_list[i].distance) slot = i;
      end
    end
    if (slot >= 0) begin
      top = (n < MAX_ENTRIES) ? n : MAX_ENTRIES - 1;
      for (int i = top; i > slot; i--) cand_list[i] = cand_list[i - 1];
      cand_list[slot] = '{vertex_key: key, distance: off_dist};
      if (n + 1 <= cap_eff) cand_count = n + 1;
      v.accepted = 1'b1;
    end else if (!hit && n < cap_eff) begin
      cand_list[n] = '{vertex_key: key, distance: off_dist};
      cand_count = n + 1;
      v.accepted = 1'b1;
    end
    v.entry_count = cand_count[4:0];
    return v;
  endfunction

  function automatic int idle_len();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7, 8: return 0;
      9, 10, 11, 12, 13: return $urandom_range(1, 3);
      14: return $urandom_range(4, 10);
      default: return $urandom_range(20, 40);
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        k = (cand_count > 0) ? cand_list[$urandom_range(0, cand_count - 1)].vertex_key
                             : $urandom;
      end
      3: k = $urandom_range(0, 15);
      4: k = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] pick_dist();
    logic [31:0] base;
    logic [31:0] d;
    base = (cand_count > 0) ? cand_list[$urandom_range(0, cand_count - 1)].distance
                            : $urandom;
    case ($urandom_range(0, 11))
      0, 1: d = base;
      2: d = base + 1;
      3: d = base - 1;
      4: d = base + $urandom_range(2, 4096);
      5, 6, 7: d = $urandom;
      8: d = $urandom >> $urandom_range(0, 31);
      9: d = 32'hFFFF_FFFF;
      10: d = {16'($urandom_range(0, 65535)), 16'h0000};
      default: d = base ^ (32'd1 << $urandom_range(0, 31));
    endcase
    return d;
  endfunction

  task automatic offer(input logic [31:0] key, input logic [31:0] off_dist, input bit typed,
                       input verdict_t want);
    verdict_t v;
    int       gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_key <= key;
    in_distance <= off_dist;
    v = rank_offer(key, off_dist);
    if (typed) v = want;
    pending_verdicts = {pending_verdicts, v};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_setting = value;
  endtask

  initial begin
    script = '{
      '{ROW_OFFER,   32'h0000_00A1, 32'd100,       5'd0,  1'b1, 1'b1, 5'd1},
      '{ROW_OFFER,   32'h0000_00A1, 32'd50,        5'd0,  1'b1, 1'b0, 5'd1},
      '{ROW_OFFER,   32'h0000_00B2, 32'd100,       5'd0,  1'b1, 1'b1, 5'd2},
      '{ROW_OFFER,   32'h0000_00C3, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b1, 5'd3},
      '{ROW_OFFER,   32'hFFFF_FFFF, 32'd0,         5'd0,  1'b1, 1'b1, 5'd4},
      '{ROW_OFFER,   32'h0000_0000, 32'd0,         5'd0,  1'b1, 1'b1, 5'd5},
      '{ROW_OFFER,   32'h0000_00B2, 32'd200,       5'd0,  1'b1, 1'b0, 5'd5},
      '{ROW_OFFER,   32'h0000_00C3, 32'd5,         5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_SET_CAP, 32'd0,         32'd0,         5'd2,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_00D4, 32'd1,         5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_00E5, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, 5'd6},
      '{ROW_SET_CAP, 32'd0,         32'd0,         5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_0077, 32'd7,         5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_SET_CAP, 32'd0,         32'd0,         5'd31, 1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_0008, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b1, 5'd7},
      '{ROW_SET_CAP, 32'd0,         32'd0,         5'd8,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_0009, 32'h8000_0000, 5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_000A, 32'd3,         5'd0,  1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'h0000_000B, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, 5'd8},
      '{ROW_SET_CAP, 32'd0,         32'd0,         5'd16, 1'b0, 1'b0, 5'd0},
      '{ROW_OFFER,   32'hFFFF_FFFF, 32'h0001_2345, 5'd0,  1'b1, 1'b0, 5'd8}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (script[r]) begin
      if (script[r].kind == ROW_SET_CAP) begin
        quiesce();
        set_capacity(script[r].cap);
      end else begin
        offer(script[r].key, script[r].dist_val, script[r].typed,
              '{script[r].want_acc, script[r].want_cnt});
      end
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      set_capacity(CAP_PLAN[p]);
      calm = (p % 4 == 2);
      repeat (PHASE_ITEMS) offer(pick_key(), pick_dist(), 1'b0, '0);
    end
    quiesce();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    verdict_t want_v;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t.", $time);
      end else begin
        want_v = pending_verdicts.pop_front();
        if (out_accepted !== want_v.accepted || out_entry_count !== want_v.entry_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: accepted exp %0b got %0b, entry_count exp %0d got %0d",
                     $time, want_v.accepted, out_accepted, want_v.entry_count,
                     out_entry_count);
          end
        end
      end
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

endmodule
